@@ rtl/core/rti_pkg.sv @@
`timescale 1ns / 1ps

package rti_pkg;

  // Field widths of the fixed-point data path.
  localparam int unsigned COORD_W = 32;   // input coordinate, signed Q format
  localparam int unsigned EDGE_W  = 33;   // difference of two coordinates
  localparam int unsigned CROSS_W = 67;   // cross product component
  localparam int unsigned DOT_W   = 104;  // dot product of cross and edge
  localparam int unsigned LO_W    = 34;   // low slice of a split multiplicand
  localparam int unsigned QUO_W   = 32;   // quotient bits, top bit flags overflow
  localparam int unsigned IDX_W   = 16;   // index field on the bus

  // Bus word layout.
  localparam int unsigned IN_DATA_W  = 304;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned ADDR_W     = 5;

  localparam logic [COORD_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] DIST_MIN = 32'h8000_0000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_DIRECTION_X,
    REG_DIRECTION_Y,
    REG_DIRECTION_Z
  } cfg_reg_e;

  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic signed [DOT_W-1:0]   dot_t;

endpackage

@@ rtl/core/ray_triangle_intersect_top.sv @@
`timescale 1ns / 1ps

// Moller-Trumbore ray/triangle test in signed fixed point. The ray origin and
// direction sit in six 32-bit APB registers (origin x,y,z then direction x,y,z
// at byte addresses 0 to 20) and must be written while no triangle is in
// flight. Each stream word carries three vertices and an index and yields one
// result word: hit, parallel, the saturated distance t and the index. The
// pipeline takes one triangle per clock when not stalled, through the cross
// and dot product multiplier stages and the 32-stage restoring divider that
// produces one quotient bit per stage. A stalled output holds the whole
// pipeline, while one extra word waits in the input skid register.
module ray_triangle_intersect_top #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned INDEX_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rti_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // Triangle stream. tdata from bit 0: vertex_a_x, vertex_a_y, vertex_a_z,
  // vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
  // triangle_index.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rti_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Result stream. tdata from bit 0: hit, parallel, hit_distance,
  // result_index, zero padding.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rti_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned IXW = (INDEX_WIDTH < rti_pkg::IDX_W) ? INDEX_WIDTH
                                                              : rti_pkg::IDX_W;
  localparam int unsigned NW  = rti_pkg::DOT_W;
  localparam int unsigned RW  = NW + rti_pkg::QUO_W;
  localparam int unsigned QW  = rti_pkg::QUO_W;
  localparam int unsigned XW  = rti_pkg::CROSS_W;
  localparam int unsigned EW  = rti_pkg::EDGE_W;
  localparam int unsigned CW  = rti_pkg::COORD_W;
  localparam int unsigned LW  = rti_pkg::LO_W;
  localparam int unsigned HW  = XW - LW;

  typedef struct packed {
    logic            hit;
    logic            par;
    logic            neg;
    logic [IXW-1:0]  idx;
    logic [NW-1:0]   det;
    logic [RW-1:0]   rem;
    logic [QW-1:0]   quo;
  } div_t;

  // Configuration registers.
  logic signed [CW-1:0] org_q [3];
  logic signed [CW-1:0] dir_q [3];
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        org_q[k] <= '0;
        dir_q[k] <= '0;
      end
    end else if (cfg_wr) begin
      case (rti_pkg::cfg_reg_e'(paddr[4:2]))
        rti_pkg::REG_ORIGIN_X:    org_q[0] <= pwdata;
        rti_pkg::REG_ORIGIN_Y:    org_q[1] <= pwdata;
        rti_pkg::REG_ORIGIN_Z:    org_q[2] <= pwdata;
        rti_pkg::REG_DIRECTION_X: dir_q[0] <= pwdata;
        rti_pkg::REG_DIRECTION_Y: dir_q[1] <= pwdata;
        rti_pkg::REG_DIRECTION_Z: dir_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (rti_pkg::cfg_reg_e'(paddr[4:2]))
      rti_pkg::REG_ORIGIN_X:    prdata = org_q[0];
      rti_pkg::REG_ORIGIN_Y:    prdata = org_q[1];
      rti_pkg::REG_ORIGIN_Z:    prdata = org_q[2];
      rti_pkg::REG_DIRECTION_X: prdata = dir_q[0];
      rti_pkg::REG_DIRECTION_Y: prdata = dir_q[1];
      rti_pkg::REG_DIRECTION_Z: prdata = dir_q[2];
      default:                  prdata = '0;
    endcase
  end

  // Pipeline advance: every stage moves when the output is empty or taken.
  logic out_v_q;
  logic adv;
  assign adv = !out_v_q || m_axis_tready;

  // Input skid register holds one word that arrives during a stall.
  logic                          skid_v_q;
  logic [rti_pkg::IN_DATA_W-1:0] skid_q;
  logic                          src_v;
  logic [rti_pkg::IN_DATA_W-1:0] src_data;

  assign s_axis_tready = !skid_v_q;
  assign src_v         = skid_v_q || s_axis_tvalid;
  assign src_data      = skid_v_q ? skid_q : s_axis_tdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (adv) begin
      skid_v_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && s_axis_tvalid && s_axis_tready) begin
      skid_q <= s_axis_tdata;
    end
  end

  // Stage 1: edge vectors and origin offset.
  logic [7:1]           v_q;
  rti_pkg::edge_t       e1_d [3], e2_d [3], s_d [3];
  rti_pkg::edge_t       e1_1_q [3], e2_1_q [3], s_1_q [3];
  logic [IXW-1:0]       idx_1_q;

  always_comb begin
    logic signed [CW-1:0] va, vb, vc;
    for (int k = 0; k < 3; k++) begin
      va = src_data[CW*k +: CW];
      vb = src_data[CW*(3+k) +: CW];
      vc = src_data[CW*(6+k) +: CW];
      e1_d[k] = EW'(vb) - EW'(va);
      e2_d[k] = EW'(vc) - EW'(va);
      s_d[k]  = EW'(org_q[k]) - EW'(va);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_1_q  <= e1_d;
      e2_1_q  <= e2_d;
      s_1_q   <= s_d;
      idx_1_q <= src_data[CW*9 +: IXW];
    end
  end

  // Stage 2: cross product terms of dir x e2 and s x e1.
  rti_pkg::cross_t pm_q [6], qm_q [6];
  rti_pkg::edge_t  e1_2_q [3], e2_2_q [3], s_2_q [3];
  logic [IXW-1:0]  idx_2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pm_q[0] <= XW'(dir_q[1]) * XW'(e2_1_q[2]);
      pm_q[1] <= XW'(dir_q[2]) * XW'(e2_1_q[1]);
      pm_q[2] <= XW'(dir_q[2]) * XW'(e2_1_q[0]);
      pm_q[3] <= XW'(dir_q[0]) * XW'(e2_1_q[2]);
      pm_q[4] <= XW'(dir_q[0]) * XW'(e2_1_q[1]);
      pm_q[5] <= XW'(dir_q[1]) * XW'(e2_1_q[0]);
      qm_q[0] <= XW'(s_1_q[1]) * XW'(e1_1_q[2]);
      qm_q[1] <= XW'(s_1_q[2]) * XW'(e1_1_q[1]);
      qm_q[2] <= XW'(s_1_q[2]) * XW'(e1_1_q[0]);
      qm_q[3] <= XW'(s_1_q[0]) * XW'(e1_1_q[2]);
      qm_q[4] <= XW'(s_1_q[0]) * XW'(e1_1_q[1]);
      qm_q[5] <= XW'(s_1_q[1]) * XW'(e1_1_q[0]);
      e1_2_q  <= e1_1_q;
      e2_2_q  <= e2_1_q;
      s_2_q   <= s_1_q;
      idx_2_q <= idx_1_q;
    end
  end

  // Stage 3: cross product components p and q.
  rti_pkg::cross_t p_q [3], q_q [3];
  rti_pkg::edge_t  e1_3_q [3], e2_3_q [3], s_3_q [3];
  logic [IXW-1:0]  idx_3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        p_q[k] <= pm_q[2*k] - pm_q[2*k+1];
        q_q[k] <= qm_q[2*k] - qm_q[2*k+1];
      end
      e1_3_q  <= e1_2_q;
      e2_3_q  <= e2_2_q;
      s_3_q   <= s_2_q;
      idx_3_q <= idx_2_q;
    end
  end

  // Stage 4: dot product terms, each split into a low and a high partial.
  rti_pkg::cross_t            ma [12];
  rti_pkg::edge_t             mb [12];
  logic signed [LW+EW:0]      pl_q [12];
  logic signed [HW+EW-1:0]    ph_q [12];
  logic [IXW-1:0]             idx_4_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ma[k]   = p_q[k];  mb[k]   = e1_3_q[k];
      ma[3+k] = q_q[k];  mb[3+k] = e2_3_q[k];
      ma[6+k] = p_q[k];  mb[6+k] = s_3_q[k];
      ma[9+k] = q_q[k];  mb[9+k] = EW'(dir_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 12; k++) begin
        pl_q[k] <= (LW+EW+1)'($signed({1'b0, ma[k][LW-1:0]})) * (LW+EW+1)'(mb[k]);
        ph_q[k] <= (HW+EW)'($signed(ma[k][XW-1:LW])) * (HW+EW)'(mb[k]);
      end
      idx_4_q <= idx_3_q;
    end
  end

  // Stage 5: recombine partials into full dot product terms.
  rti_pkg::dot_t  prod_q [12];
  logic [IXW-1:0] idx_5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 12; k++) begin
        prod_q[k] <= (NW'(ph_q[k]) <<< LW) + NW'(pl_q[k]);
      end
      idx_5_q <= idx_4_q;
    end
  end

  // Stage 6: determinant and the three numerators.
  rti_pkg::dot_t  dsum_q [4];
  logic [IXW-1:0] idx_6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        dsum_q[j] <= prod_q[3*j] + prod_q[3*j+1] + prod_q[3*j+2];
      end
      idx_6_q <= idx_5_q;
    end
  end

  // Stage 7: flip signs so that the determinant is not negative.
  rti_pkg::dot_t  det_7_q, nt_7_q, nb_7_q, ng_7_q;
  logic           par_7_q;
  logic [IXW-1:0] idx_7_q;
  logic           dneg;

  assign dneg = dsum_q[0][NW-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      det_7_q <= dneg ? -dsum_q[0] : dsum_q[0];
      nt_7_q  <= dneg ? -dsum_q[1] : dsum_q[1];
      nb_7_q  <= dneg ? -dsum_q[2] : dsum_q[2];
      ng_7_q  <= dneg ? -dsum_q[3] : dsum_q[3];
      par_7_q <= (dsum_q[0] == '0);
      idx_7_q <= idx_6_q;
    end
  end

  // Stage 8: hit decision and divider setup.
  logic [QW:0]        dv_q;
  div_t               div_q [QW+1];
  div_t               div_in;
  logic signed [NW:0] nsum, det_x;
  rti_pkg::dot_t      nt_abs;

  always_comb begin
    nsum   = (NW+1)'(nb_7_q) + (NW+1)'(ng_7_q);
    det_x  = (NW+1)'(det_7_q);
    nt_abs = nt_7_q[NW-1] ? -nt_7_q : nt_7_q;
    div_in.hit = !par_7_q && !nt_7_q[NW-1] &&
                 !nb_7_q[NW-1] && (nb_7_q <= det_7_q) &&
                 !ng_7_q[NW-1] && (ng_7_q <= det_7_q) &&
                 !nsum[NW] && (nsum <= det_x);
    div_in.par = par_7_q;
    div_in.neg = nt_7_q[NW-1];
    div_in.idx = idx_7_q;
    div_in.det = det_7_q;
    div_in.rem = RW'(nt_abs) << FRAC_BITS;
    div_in.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0] <= div_in;
    end
  end

  // Divider: one quotient bit per stage, most significant first. A set top
  // bit means the quotient does not fit and the distance saturates.
  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int unsigned BIT = QW - 1 - g;
    logic [RW-1:0] dsh;
    logic          ge;
    div_t          nxt;

    always_comb begin
      dsh = RW'(div_q[g].det) << BIT;
      ge  = div_q[g].rem >= dsh;
      nxt = div_q[g];
      if (ge) begin
        nxt.rem      = div_q[g].rem - dsh;
        nxt.quo[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[g+1] <= nxt;
      end
    end
  end

  // Valid bits travel alongside the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      dv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q     <= {v_q[6:1], src_v};
      dv_q    <= {dv_q[QW-1:0], v_q[7]};
      out_v_q <= dv_q[QW];
    end
  end

  // Output register: saturate and sign the distance.
  logic [CW-1:0]  dist_d, dist_q;
  logic           hit_q, par_q;
  logic [IXW-1:0] idx_q;
  div_t           dlast;

  assign dlast = div_q[QW];

  always_comb begin
    if (dlast.par) begin
      dist_d = '0;
    end else if (dlast.quo[QW-1]) begin
      dist_d = dlast.neg ? rti_pkg::DIST_MIN : rti_pkg::DIST_MAX;
    end else begin
      dist_d = dlast.neg ? -dlast.quo : dlast.quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= dist_d;
      hit_q  <= dlast.hit;
      par_q  <= dlast.par;
      idx_q  <= dlast.idx;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(rti_pkg::OUT_DATA_W - 2 - CW - rti_pkg::IDX_W){1'b0}},
                          rti_pkg::IDX_W'(idx_q), dist_q, par_q, hit_q};

  // A word enters the skid register only while the pipeline is held.
  a_skid_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !adv) |=> skid_v_q)
    else $error("skid register missed a word during a stall");

  // The skid register is only occupied while a result waits at the output.
  a_skid_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full with an empty output");

  // A parallel result never reports a hit and carries zero distance.
  a_par: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && par_q) |-> (!hit_q && dist_q == '0))
    else $error("parallel result with hit or distance");

  // A hold keeps every stage's valid bit in place.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({v_q, dv_q, out_v_q}))
    else $error("pipeline moved during a stall");

endmodule
